// ===== rtl/omc_pkg.sv =====
// shared constants and types for the oversampled moisture calibrator
package omc_pkg;

  localparam int OVERSAMPLE = 16;
  localparam int N_EFF      = (OVERSAMPLE < 1) ? 1 : OVERSAMPLE;

  localparam int ADC_W   = 12;
  localparam int PCT_W   = 10;
  localparam int TEN_W   = 11;
  localparam int CNT_W   = (N_EFF > 1) ? $clog2(N_EFF) : 1;
  localparam int TOTAL_W = ADC_W + $clog2(N_EFF);
  localparam int PROD_W  = 22;
  localparam int DIV_W   = (TOTAL_W > PROD_W) ? TOTAL_W : PROD_W;
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  localparam logic [ADC_W-1:0] ADC_MAX    = 12'd4095;
  localparam logic [9:0]       FULL_SCALE = 10'd1000;
  localparam logic [TEN_W-1:0] INVALID_TENTHS = -11'sd10;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_READ_ERR = 2'd1;
  localparam logic [1:0] STATUS_SIM     = 2'd2;
  localparam logic [1:0] STATUS_CAL_ERR = 2'd3;

  localparam logic [1:0] REG_ADC_DRY     = 2'd0;
  localparam logic [1:0] REG_ADC_WET     = 2'd1;
  localparam logic [1:0] REG_SIM_ENABLE  = 2'd2;
  localparam logic [1:0] REG_SIM_PERCENT = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_MAP_DIV,
    S_DONE
  } state_t;

endpackage

// ===== rtl/oversampled_moisture_calibrator_core.sv =====
// oversampled moisture calibrator: accumulate, average and map to tenths of percent
// a sample that does not close the window is only accumulated and gives no result
// the closing sample is checked, multiplied and divided by the span on one restoring
// divider (one quotient bit per cycle, 22 bits), then the result waits in the done state for the output register
// pinned mean or zero span skips the divider; sim mode bypasses the window; input waits while a result is held
// synchronous reset clears the accumulator, the registers and the output valid
module oversampled_moisture_calibrator_core
  import omc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [ADC_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ADC_W-1:0]        adc_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ADC_W-1:0]        average_raw,
  output logic signed [TEN_W-1:0] moisture_tenths,
  output logic [1:0]              status
);

  logic [ADC_W-1:0]   adc_dry;
  logic [ADC_W-1:0]   adc_wet;
  logic               sim_enable;
  logic [PCT_W-1:0]   sim_percent;

  logic [TOTAL_W-1:0] sample_total;
  logic [CNT_W-1:0]   samples_taken;

  state_t             state;
  state_t             state_next;

  // restoring divider
  logic [DIV_W-1:0]   quo;
  logic [ADC_W-1:0]   rem;
  logic [ADC_W-1:0]   divisor;
  logic [DCNT_W-1:0]  div_cnt;
  logic [ADC_W:0]     rem_sh;
  logic               take;
  logic               div_busy;

  logic [ADC_W-1:0]   avg;
  logic               neg;
  logic [ADC_W-1:0]   res_avg;
  logic [TEN_W-1:0]   res_tenths;
  logic [1:0]         res_status;

  logic               in_xfer;
  logic               out_free;
  logic               last_sample;
  logic [TOTAL_W-1:0] total_sum;
  logic [ADC_W-1:0]   total_mean;
  logic [ADC_W:0]     diff;
  logic [ADC_W:0]     span;
  logic [ADC_W-1:0]   diff_abs;
  logic [ADC_W-1:0]   span_abs;
  logic [PROD_W-1:0]  product;
  logic [PCT_W-1:0]   sim_sat;
  logic [TEN_W-1:0]   map_tenths;

  assign out_free    = !out_valid || out_ready;
  assign in_ready    = (state == S_IDLE) && out_free;
  assign in_xfer     = in_valid && in_ready;
  assign last_sample = (samples_taken == CNT_W'(N_EFF - 1));
  assign total_sum   = sample_total + TOTAL_W'(adc_sample);
  // window length is a power of two, so this is a shift
  assign total_mean  = ADC_W'(total_sum / TOTAL_W'(N_EFF));

  assign rem_sh   = {rem, quo[DIV_W-1]};
  assign take     = (rem_sh >= {1'b0, divisor});
  assign div_busy = (div_cnt != '0);

  assign diff     = {1'b0, adc_dry} - {1'b0, avg};
  assign span     = {1'b0, adc_dry} - {1'b0, adc_wet};
  assign diff_abs = diff[ADC_W] ? ADC_W'(-diff) : diff[ADC_W-1:0];
  assign span_abs = span[ADC_W] ? ADC_W'(-span) : span[ADC_W-1:0];
  assign product  = PROD_W'(diff_abs) * PROD_W'(FULL_SCALE);
  assign sim_sat  = (sim_percent > FULL_SCALE) ? FULL_SCALE : sim_percent;

  // negative quotient clamps to zero, large one to full scale
  always_comb begin
    if (neg) begin
      map_tenths = '0;
    end else if (quo > DIV_W'(FULL_SCALE)) begin
      map_tenths = TEN_W'(FULL_SCALE);
    end else begin
      map_tenths = quo[TEN_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && !sim_enable && last_sample) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (avg == '0 || avg == ADC_MAX || adc_dry == adc_wet) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL:     state_next = S_MAP_DIV;
      S_MAP_DIV: begin
        if (!div_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_dry     <= ADC_MAX;
      adc_wet     <= '0;
      sim_enable  <= 1'b0;
      sim_percent <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ADC_DRY:     adc_dry     <= cfg_data;
        REG_ADC_WET:     adc_wet     <= cfg_data;
        REG_SIM_ENABLE:  sim_enable  <= cfg_data[0];
        REG_SIM_PERCENT: sim_percent <= cfg_data[PCT_W-1:0];
        default:         ;
      endcase
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_total  <= '0;
      samples_taken <= '0;
    end else if (in_xfer && !sim_enable) begin
      if (last_sample) begin
        sample_total  <= '0;
        samples_taken <= '0;
      end else begin
        sample_total  <= total_sum;
        samples_taken <= samples_taken + 1'b1;
      end
    end
  end

  // divider and result datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else begin
      if (div_busy) begin
        quo     <= {quo[DIV_W-2:0], take};
        rem     <= take ? ADC_W'(rem_sh - {1'b0, divisor}) : rem_sh[ADC_W-1:0];
        div_cnt <= div_cnt - 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer && !sim_enable && last_sample) begin
            avg     <= total_mean;
            res_avg <= total_mean;
          end
        end
        S_CHECK: begin
          if (avg == '0 || avg == ADC_MAX) begin
            res_tenths <= INVALID_TENTHS;
            res_status <= STATUS_READ_ERR;
          end else if (adc_dry == adc_wet) begin
            res_tenths <= INVALID_TENTHS;
            res_status <= STATUS_CAL_ERR;
          end
        end
        S_MUL: begin
          quo     <= DIV_W'(product);
          rem     <= '0;
          divisor <= span_abs;
          neg     <= (diff[ADC_W] ^ span[ADC_W]) && (diff_abs != '0);
          div_cnt <= DCNT_W'(DIV_W);
        end
        S_MAP_DIV: begin
          if (!div_busy) begin
            res_tenths <= map_tenths;
            res_status <= STATUS_OK;
          end
        end
        S_DONE:  ;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && sim_enable) begin
      out_valid       <= 1'b1;
      average_raw     <= '0;
      moisture_tenths <= signed'(TEN_W'(sim_sat));
      status          <= STATUS_SIM;
    end else if (state == S_DONE && out_free) begin
      out_valid       <= 1'b1;
      average_raw     <= res_avg;
      moisture_tenths <= signed'(res_tenths);
      status          <= res_status;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
